[hdl/grwi_pkg.sv]
// Shared constants, types and the tangent table for the grid ray wall intersection block.
`timescale 1ns / 1ps

package grwi_pkg;

	localparam int GRID_COLS   = 32;
	localparam int GRID_ROWS   = 32;
	localparam int CELL_PIXELS = 64;

	localparam int COL_W     = $clog2(GRID_COLS);
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int MAP_DEPTH = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W    = $clog2(MAP_DEPTH);
	localparam int CELL_SH   = $clog2(CELL_PIXELS);

	localparam int CFG_W   = 6;
	localparam int CIDX_W  = 2;
	localparam int POS_IN_W = 11;
	localparam int ANG_W   = 9;
	localparam int HIT_W   = 12;
	localparam int POS_W   = 16;
	localparam int FRAC    = 16;
	localparam int T_W     = 24;
	localparam int D_W     = CELL_SH + 2;
	localparam int DIV_W   = CELL_SH + 1 + FRAC;
	localparam int TAN_N   = 90;

	localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;
	localparam logic [7:0] CELL_WALL = 8'd1;

	localparam longint Q30_ONE  = 64'sd1073741824;
	localparam longint COS_ONE  = 64'sd1073578288;
	localparam longint SIN_ONE  = 64'sd18739379;

	typedef logic signed [T_W-1:0] tan_tab_t [TAN_N];

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_CAPTURE,
		OP_LOOKUP,
		OP_VSTART,
		OP_HSTART,
		OP_DIV_OFS,
		OP_DIV_STEP,
		OP_SET_OFS,
		OP_SET_STEP,
		OP_STEP,
		OP_VHIT,
		OP_VMISS,
		OP_HHIT,
		OP_HMISS,
		OP_PUBLISH
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_VSTART,
		ST_VADDR,
		ST_VDATA,
		ST_HSTART,
		ST_DIV_OFS,
		ST_WAIT_OFS,
		ST_DIV_STEP,
		ST_WAIT_STEP,
		ST_HADDR,
		ST_HDATA,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic inf;
		logic skip_h;
		logic oob;
		logic wall;
		logic div_busy;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

	function automatic longint round_q30(longint v);
		longint r;
		if (v >= 0) begin
			r = (v + (Q30_ONE >>> 1)) >>> 30;
		end else begin
			r = -((-v + (Q30_ONE >>> 1)) >>> 30);
		end
		return r;
	endfunction

	// Tangents of 0..89 degrees in 24-bit signed Q7.16, from a unit vector rotated one degree at a time.
	function automatic tan_tab_t build_tan();
		tan_tab_t tab;
		longint c;
		longint s;
		longint nc;
		longint ns;
		longint num;
		longint q;
		longint rem;
		c = Q30_ONE;
		s = 0;
		for (int k = 0; k < TAN_N; k++) begin
			num = s * 65536 + (c >>> 1);
			q = 0;
			rem = 0;
			for (int b = 47; b >= 0; b--) begin
				rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
				if (rem >= c) begin
					rem = rem - c;
					q = q | (64'sd1 <<< b);
				end
			end
			tab[k] = T_W'(q);
			nc = round_q30(c * COS_ONE - s * SIN_ONE);
			ns = round_q30(s * COS_ONE + c * SIN_ONE);
			c = nc;
			s = ns;
		end
		return tab;
	endfunction

	localparam tan_tab_t TAN_TAB = build_tan();

endpackage

[hdl/grwi_ram.sv]
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module grwi_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/grwi_div.sv]
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps

module grwi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [grwi_pkg::DIV_W-1:0] dividend,
	input  logic [grwi_pkg::DIV_W-1:0] divisor,
	output logic                       busy,
	output logic [grwi_pkg::DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(grwi_pkg::DIV_W + 1);

	logic [CNT_W-1:0]                cnt_q;
	logic [grwi_pkg::DIV_W-1:0]      rem_q;
	logic [grwi_pkg::DIV_W-1:0]      quo_q;
	logic [grwi_pkg::DIV_W-1:0]      dvs_q;
	logic [grwi_pkg::DIV_W:0]        trial;
	logic                            fits;

	assign trial = {rem_q, quo_q[grwi_pkg::DIV_W-1]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(grwi_pkg::DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? grwi_pkg::DIV_W'(trial - {1'b0, dvs_q})
			              : grwi_pkg::DIV_W'(trial);
			quo_q <= {quo_q[grwi_pkg::DIV_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quotient = quo_q;

endmodule

[hdl/grwi_ctrl.sv]
// Sequencer for map clearing, loads and the two grid walks of a cast.
`timescale 1ns / 1ps

module grwi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cmd,
	output logic               in_ready,
	input  grwi_pkg::dp_stat_t stat,
	output grwi_pkg::op_t      op
);

	grwi_pkg::state_t state_q;
	grwi_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grwi_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op = grwi_pkg::OP_NONE;
		unique case (state_q)
			grwi_pkg::ST_CLEAR: begin
				op = grwi_pkg::OP_CLEAR;
				if (stat.clr_last) state_d = grwi_pkg::ST_IDLE;
			end
			grwi_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!cmd) begin
						op = grwi_pkg::OP_LOAD;
					end else begin
						op = grwi_pkg::OP_CAPTURE;
						state_d = grwi_pkg::ST_LOOKUP;
					end
				end
			end
			grwi_pkg::ST_LOOKUP: begin
				op = grwi_pkg::OP_LOOKUP;
				state_d = grwi_pkg::ST_VSTART;
			end
			grwi_pkg::ST_VSTART: begin
				if (stat.inf) begin
					op = grwi_pkg::OP_VMISS;
					state_d = grwi_pkg::ST_HSTART;
				end else begin
					op = grwi_pkg::OP_VSTART;
					state_d = grwi_pkg::ST_VADDR;
				end
			end
			grwi_pkg::ST_VADDR: begin
				if (stat.oob) begin
					op = grwi_pkg::OP_VMISS;
					state_d = grwi_pkg::ST_HSTART;
				end else begin
					state_d = grwi_pkg::ST_VDATA;
				end
			end
			grwi_pkg::ST_VDATA: begin
				if (stat.wall) begin
					op = grwi_pkg::OP_VHIT;
					state_d = grwi_pkg::ST_HSTART;
				end else begin
					op = grwi_pkg::OP_STEP;
					state_d = grwi_pkg::ST_VADDR;
				end
			end
			grwi_pkg::ST_HSTART: begin
				if (stat.skip_h) begin
					op = grwi_pkg::OP_HMISS;
					state_d = grwi_pkg::ST_FINISH;
				end else begin
					op = grwi_pkg::OP_HSTART;
					state_d = stat.inf ? grwi_pkg::ST_HADDR : grwi_pkg::ST_DIV_OFS;
				end
			end
			grwi_pkg::ST_DIV_OFS: begin
				op = grwi_pkg::OP_DIV_OFS;
				state_d = grwi_pkg::ST_WAIT_OFS;
			end
			grwi_pkg::ST_WAIT_OFS: begin
				if (!stat.div_busy) begin
					op = grwi_pkg::OP_SET_OFS;
					state_d = grwi_pkg::ST_DIV_STEP;
				end
			end
			grwi_pkg::ST_DIV_STEP: begin
				op = grwi_pkg::OP_DIV_STEP;
				state_d = grwi_pkg::ST_WAIT_STEP;
			end
			grwi_pkg::ST_WAIT_STEP: begin
				if (!stat.div_busy) begin
					op = grwi_pkg::OP_SET_STEP;
					state_d = grwi_pkg::ST_HADDR;
				end
			end
			grwi_pkg::ST_HADDR: begin
				if (stat.oob) begin
					op = grwi_pkg::OP_HMISS;
					state_d = grwi_pkg::ST_FINISH;
				end else begin
					state_d = grwi_pkg::ST_HDATA;
				end
			end
			grwi_pkg::ST_HDATA: begin
				if (stat.wall) begin
					op = grwi_pkg::OP_HHIT;
					state_d = grwi_pkg::ST_FINISH;
				end else begin
					op = grwi_pkg::OP_STEP;
					state_d = grwi_pkg::ST_HADDR;
				end
			end
			grwi_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					op = grwi_pkg::OP_PUBLISH;
					state_d = grwi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = grwi_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_ready = state_q == grwi_pkg::ST_IDLE;

endmodule

[hdl/grwi_dp.sv]
// Datapath: wall map, configuration, walk position registers, divider and result register.
`timescale 1ns / 1ps

module grwi_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  grwi_pkg::op_t                       op,
	output grwi_pkg::dp_stat_t                  stat,
	input  logic                                cfg_valid,
	input  logic [grwi_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [grwi_pkg::CFG_W-1:0]          cfg_data,
	input  logic [4:0]                          cell_row,
	input  logic [4:0]                          cell_col,
	input  logic [7:0]                          cell_type,
	input  logic [grwi_pkg::POS_IN_W-1:0]       pos_x,
	input  logic [grwi_pkg::POS_IN_W-1:0]       pos_y,
	input  logic [grwi_pkg::ANG_W-1:0]          angle_deg,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                vert_found,
	output logic signed [grwi_pkg::HIT_W-1:0]   vert_hit_x,
	output logic signed [grwi_pkg::HIT_W-1:0]   vert_hit_y,
	output logic                                hor_found,
	output logic signed [grwi_pkg::HIT_W-1:0]   hor_hit_x,
	output logic signed [grwi_pkg::HIT_W-1:0]   hor_hit_y
);

	localparam int PW = grwi_pkg::POS_W;
	localparam int AW = grwi_pkg::ADDR_W;
	localparam logic signed [PW-1:0] CELL_S = PW'(grwi_pkg::CELL_PIXELS);
	localparam logic signed [PW-1:0] CELL_MASK = ~PW'(grwi_pkg::CELL_PIXELS - 1);

	logic [grwi_pkg::CFG_W-1:0]      gw_q;
	logic [grwi_pkg::CFG_W-1:0]      gh_q;
	logic [AW-1:0]                   clr_q;
	logic [grwi_pkg::POS_IN_W-1:0]   px_q;
	logic [grwi_pkg::POS_IN_W-1:0]   py_q;
	logic [grwi_pkg::ANG_W-1:0]      ang_q;
	logic signed [grwi_pkg::T_W-1:0] t_q;
	logic                            inf_q;
	logic                            left_q;
	logic                            up_q;
	logic                            skip_h_q;
	logic signed [PW-1:0]            cur_x_q;
	logic signed [PW-1:0]            cur_y_q;
	logic signed [PW-1:0]            dx_q;
	logic signed [PW-1:0]            dy_q;
	logic signed [grwi_pkg::D_W-1:0] d_q;
	logic                            vf_q;
	logic                            hf_q;
	logic signed [grwi_pkg::HIT_W-1:0] vx_q;
	logic signed [grwi_pkg::HIT_W-1:0] vy_q;
	logic signed [grwi_pkg::HIT_W-1:0] hx_q;
	logic signed [grwi_pkg::HIT_W-1:0] hy_q;
	logic                            out_valid_q;

	// Table lookup.
	logic [7:0]                      ang_r;
	logic [6:0]                      tab_idx;
	logic signed [grwi_pkg::T_W-1:0] t_look;

	always_comb begin
		ang_r = (ang_q < 9'd180) ? ang_q[7:0] : 8'(ang_q - 9'd180);
		tab_idx = (ang_r < 8'd90) ? ang_r[6:0] : 7'(8'd180 - ang_r);
		if (ang_r < 8'd90) begin
			t_look = grwi_pkg::TAN_TAB[tab_idx];
		end else if (ang_r == 8'd90) begin
			t_look = '0;
		end else begin
			t_look = -grwi_pkg::TAN_TAB[tab_idx];
		end
	end

	// Walk start points.
	logic signed [PW-1:0]            px_e;
	logic signed [PW-1:0]            py_e;
	logic signed [PW-1:0]            vx_start;
	logic signed [PW-1:0]            hy_start;
	logic signed [grwi_pkg::D_W-1:0] vdx;
	logic signed [grwi_pkg::D_W+grwi_pkg::T_W-1:0] prod;
	logic [grwi_pkg::D_W+grwi_pkg::T_W-1:0] prod_mag;
	logic signed [PW-1:0]            vofs;
	logic [grwi_pkg::T_W-1:0]        t_mag;
	logic signed [PW-1:0]            vstep;

	always_comb begin
		px_e = PW'(px_q);
		py_e = PW'(py_q);
		vx_start = left_q ? (px_e & CELL_MASK) - PW'(1) : (px_e & CELL_MASK) + CELL_S;
		hy_start = up_q ? (py_e & CELL_MASK) - PW'(1) : (py_e & CELL_MASK) + CELL_S;
		vdx = grwi_pkg::D_W'(px_e - vx_start);
		prod = vdx * t_q;
		prod_mag = prod[$bits(prod)-1] ? unsigned'(-prod) : unsigned'(prod);
		vofs = prod[$bits(prod)-1] ? -PW'(prod_mag >> grwi_pkg::FRAC)
		                           : PW'(prod_mag >> grwi_pkg::FRAC);
		t_mag = t_q[grwi_pkg::T_W-1] ? unsigned'(-t_q) : unsigned'(t_q);
		vstep = PW'(t_mag >> (grwi_pkg::FRAC - grwi_pkg::CELL_SH));
	end

	// Divider for the horizontal walk offsets.
	logic [grwi_pkg::D_W-2:0]   d_mag;
	logic                       div_start;
	logic [grwi_pkg::DIV_W-1:0] div_num;
	logic                       div_busy;
	logic [grwi_pkg::DIV_W-1:0] div_quo;
	logic signed [PW-1:0]       quo_s;
	logic                       ofs_neg;

	assign d_mag = (grwi_pkg::D_W-1)'(d_q[grwi_pkg::D_W-1] ? -d_q : d_q);
	assign div_start = (op == grwi_pkg::OP_DIV_OFS) || (op == grwi_pkg::OP_DIV_STEP);
	assign div_num = (op == grwi_pkg::OP_DIV_STEP)
		? (grwi_pkg::DIV_W'(grwi_pkg::CELL_PIXELS) << grwi_pkg::FRAC)
		: (grwi_pkg::DIV_W'(d_mag) << grwi_pkg::FRAC);
	assign quo_s = PW'(div_quo);
	assign ofs_neg = d_q[grwi_pkg::D_W-1] ^ t_q[grwi_pkg::T_W-1];

	grwi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (grwi_pkg::DIV_W'(t_mag)),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Cell index of the current walk point and its bounds check.
	logic signed [PW-1:0] xi;
	logic signed [PW-1:0] yi;
	logic signed [PW-1:0] w_lim;
	logic signed [PW-1:0] h_lim;
	logic                 oob;
	logic [AW-1:0]        rd_addr;

	always_comb begin
		xi = cur_x_q >>> grwi_pkg::CELL_SH;
		yi = cur_y_q >>> grwi_pkg::CELL_SH;
		w_lim = (PW'(gw_q) > PW'(grwi_pkg::GRID_COLS)) ? PW'(grwi_pkg::GRID_COLS) : PW'(gw_q);
		h_lim = (PW'(gh_q) > PW'(grwi_pkg::GRID_ROWS)) ? PW'(grwi_pkg::GRID_ROWS) : PW'(gh_q);
		oob = (xi < 0) || (yi < 0) || (xi >= w_lim) || (yi >= h_lim);
		rd_addr = AW'(AW'(yi[grwi_pkg::ROW_W-1:0]) * AW'(grwi_pkg::GRID_COLS)
		              + AW'(xi[grwi_pkg::COL_W-1:0]));
	end

	// Map writes: the clearing sweep after reset, then loads.
	logic          load_ok;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_rdata;

	always_comb begin
		load_ok = (9'(cell_row) < 9'(grwi_pkg::GRID_ROWS))
		       && (9'(cell_col) < 9'(grwi_pkg::GRID_COLS));
		ram_we = (op == grwi_pkg::OP_CLEAR) || ((op == grwi_pkg::OP_LOAD) && load_ok);
		if (op == grwi_pkg::OP_CLEAR) begin
			ram_waddr = clr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_waddr = AW'(AW'(cell_row) * AW'(grwi_pkg::GRID_COLS) + AW'(cell_col));
			ram_wdata = cell_type == grwi_pkg::CELL_WALL;
		end
	end

	grwi_ram #(
		.WIDTH (1),
		.DEPTH (grwi_pkg::MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= grwi_pkg::CFG_RESET;
			gh_q <= grwi_pkg::CFG_RESET;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && (cfg_index == grwi_pkg::REG_WIDTH)) gw_q <= cfg_data;
			if (cfg_valid && (cfg_index == grwi_pkg::REG_HEIGHT)) gh_q <= cfg_data;
			if (op == grwi_pkg::OP_CLEAR) clr_q <= clr_q + 1'b1;
			if (op == grwi_pkg::OP_PUBLISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			grwi_pkg::OP_CAPTURE: begin
				px_q <= pos_x;
				py_q <= pos_y;
				ang_q <= (angle_deg >= 9'd360) ? angle_deg - 9'd360 : angle_deg;
			end
			grwi_pkg::OP_LOOKUP: begin
				t_q <= t_look;
				inf_q <= ang_r == 8'd90;
				left_q <= (ang_q > 9'd90) && (ang_q < 9'd270);
				up_q <= ang_q < 9'd180;
				skip_h_q <= (ang_q == 9'd0) || (ang_q == 9'd180);
			end
			grwi_pkg::OP_VSTART: begin
				cur_x_q <= vx_start;
				cur_y_q <= py_e + vofs;
				dx_q <= left_q ? -CELL_S : CELL_S;
				dy_q <= up_q ? -vstep : vstep;
			end
			grwi_pkg::OP_HSTART: begin
				cur_x_q <= px_e;
				cur_y_q <= hy_start;
				dx_q <= '0;
				dy_q <= up_q ? -CELL_S : CELL_S;
				d_q <= grwi_pkg::D_W'(py_e - hy_start);
			end
			grwi_pkg::OP_SET_OFS: begin
				cur_x_q <= px_e + (ofs_neg ? -quo_s : quo_s);
			end
			grwi_pkg::OP_SET_STEP: begin
				dx_q <= left_q ? -quo_s : quo_s;
			end
			grwi_pkg::OP_STEP: begin
				cur_x_q <= cur_x_q + dx_q;
				cur_y_q <= cur_y_q + dy_q;
			end
			grwi_pkg::OP_VHIT: begin
				vf_q <= 1'b1;
				vx_q <= grwi_pkg::HIT_W'(cur_x_q);
				vy_q <= grwi_pkg::HIT_W'(cur_y_q);
			end
			grwi_pkg::OP_VMISS: begin
				vf_q <= 1'b0;
				vx_q <= '0;
				vy_q <= '0;
			end
			grwi_pkg::OP_HHIT: begin
				hf_q <= 1'b1;
				hx_q <= grwi_pkg::HIT_W'(cur_x_q);
				hy_q <= grwi_pkg::HIT_W'(cur_y_q);
			end
			grwi_pkg::OP_HMISS: begin
				hf_q <= 1'b0;
				hx_q <= '0;
				hy_q <= '0;
			end
			grwi_pkg::OP_PUBLISH: begin
				vert_found <= vf_q;
				vert_hit_x <= vx_q;
				vert_hit_y <= vy_q;
				hor_found <= hf_q;
				hor_hit_x <= hx_q;
				hor_hit_y <= hy_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	assign stat.inf = inf_q;
	assign stat.skip_h = skip_h_q;
	assign stat.oob = oob;
	assign stat.wall = ram_rdata;
	assign stat.div_busy = div_busy;
	assign stat.clr_last = clr_q == AW'(grwi_pkg::MAP_DEPTH - 1);
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

[hdl/grid_ray_wall_intersection.sv]
// Grid ray wall intersection: 32 by 32 wall map with up to two grid-line ray walks per cast.
//
// Input channel (in_valid/in_ready): a beat with cmd 0 writes one map cell and is
// taken while the block stays idle, with no result. A beat with cmd 1 casts a ray
// and yields one result beat on the output channel (out_valid/out_ready).
// The configuration channel (cfg_valid/cfg_ready) is always ready; index 0 sets
// the columns in use, index 1 the rows in use. Write it only while the block is idle.
// A cast runs a setup phase, then visits map cells along each walk; every step
// waits for the registered map read, and a walk that leaves the grid ends at its
// bounds check. A horizontal walk that is not on an axis first runs two serial
// divisions, for its offset and then its step, with a handoff after each.
// in_ready stays low for the whole cast.
// After reset the map is cleared by a sweep over all 1024 cells, one cell per cycle,
// during which no input beat is taken; configuration writes are taken as usual.
// The result sits in an output register. If the receiver stalls, a new cast may
// still be accepted and computed, and it waits at its end until the held result
// has been taken.
`timescale 1ns / 1ps

module grid_ray_wall_intersection (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [4:0]                          cell_row,
	input  logic [4:0]                          cell_col,
	input  logic [7:0]                          cell_type,
	input  logic [grwi_pkg::POS_IN_W-1:0]       pos_x,
	input  logic [grwi_pkg::POS_IN_W-1:0]       pos_y,
	input  logic [grwi_pkg::ANG_W-1:0]          angle_deg,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                vert_found,
	output logic signed [grwi_pkg::HIT_W-1:0]   vert_hit_x,
	output logic signed [grwi_pkg::HIT_W-1:0]   vert_hit_y,
	output logic                                hor_found,
	output logic signed [grwi_pkg::HIT_W-1:0]   hor_hit_x,
	output logic signed [grwi_pkg::HIT_W-1:0]   hor_hit_y,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [grwi_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [grwi_pkg::CFG_W-1:0]          cfg_data
);

	grwi_pkg::op_t      op;
	grwi_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	grwi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.stat     (stat),
		.op       (op)
	);

	grwi_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_type  (cell_type),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.angle_deg  (angle_deg),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.vert_found (vert_found),
		.vert_hit_x (vert_hit_x),
		.vert_hit_y (vert_hit_y),
		.hor_found  (hor_found),
		.hor_hit_x  (hor_hit_x),
		.hor_hit_y  (hor_hit_y)
	);

endmodule
